// ===== rtl/core/rpn_stack_calculator_macros.svh =====
// Assertion macros shared by the RPN calculator RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
// No dependencies; every RTL file of the calculator imports it.
package rsc_pkg;

    localparam int WORD_W              = 32;
    localparam int OPCODE_W            = 3;
    localparam int DEPTH_W             = 5;
    localparam int STATUS_W            = 2;
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int S_TDATA_W           = 32;
    localparam int M_TDATA_W           = 40;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_UNDER,
        ST_OVER,
        ST_DIVZERO
    } status_t;

    // Divider handshake back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/core/rsc_stack_mem.sv =====
// Operand stack storage: one write port, one read port, registered read data.
// Depends on rsc_pkg for the word width.
module rsc_stack_mem #(
    parameter int DEPTH  = rsc_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [rsc_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [rsc_pkg::WORD_W-1:0] rd_data
);
    import rsc_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rsc_divider.sv =====
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on rsc_pkg and the shared assertion macros.
`include "rpn_stack_calculator_macros.svh"

module rsc_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rsc_pkg::WORD_W-1:0]  dividend,
    input  logic [rsc_pkg::WORD_W-1:0]  divisor,
    output rsc_pkg::div_status_t        stat,
    output logic [rsc_pkg::WORD_W-1:0]  quotient
);
    import rsc_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   step_reg;
    logic [WORD_W-1:0]  rem_reg;
    logic [WORD_W-1:0]  quo_reg;
    logic [WORD_W-1:0]  dvs_reg;
    logic               neg_reg;

    logic [WORD_W-1:0]  mag_a;
    logic [WORD_W-1:0]  mag_b;
    logic [WORD_W:0]    shifted;
    logic [WORD_W:0]    trial;
    logic               fits;
    logic               last_step;

    assign mag_a     = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b     = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;
    assign shifted   = {rem_reg, quo_reg[WORD_W-1]};
    assign trial     = shifted - {1'b0, dvs_reg};
    assign fits      = (shifted >= {1'b0, dvs_reg});
    assign last_step = busy_reg && (step_reg == LAST_STEP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            // Done pulses for one cycle right after the last quotient bit.
            done_reg <= last_step && !start;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= mag_a;
                dvs_reg  <= mag_b;
                neg_reg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            end else if (busy_reg) begin
                rem_reg  <= fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
                quo_reg  <= {quo_reg[WORD_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    `RSC_ASSERT_IMP(a_done_not_busy, done_reg, !busy_reg, "divider done while still busy")
    `RSC_ASSERT_NXT(a_start_busy, start, busy_reg && (step_reg == '0), "division not started")
    `RSC_ASSERT_NXT(a_last_done, last_step && !start, done_reg, "missing done")
    `RSC_ASSERT_IMP(a_no_restart, start, !busy_reg, "divider restarted mid division")

endmodule

// ===== rtl/core/rpn_stack_calculator.sv =====
// Top level of the RPN integer stack calculator.
// Depends on rsc_pkg, rsc_stack_mem, rsc_divider and the shared assertion macros.
//
// One item on the input stream is one already-tokenized RPN token: s_tuser carries
// the opcode (push, add, subtract, multiply, divide) and s_tdata the signed 32-bit
// value that a push places on the stack. An operator pops b, then a, and pushes
// a op b; add, subtract and multiply wrap modulo 2^32, and divide truncates toward
// zero (the most negative value divided by -1 wraps to itself). Every input item
// yields exactly one output item holding the top of the stack (zero when empty),
// the depth masked to five bits, and a status. Underflow, overflow and divide by
// zero leave the stack untouched and are only flagged; unknown opcodes are ignored
// with status ok. The stack entries sit in a one-port-read, one-port-write memory
// with registered read data, while the top entry is also kept in a register,
// so an operator needs a single memory read of the entry below the top. Items are
// handled one at a time: a push, an overflow, an underflow or an ignored opcode
// goes straight to the finish state; add, subtract, multiply and a divide by zero
// first pass through the read state for the memory read, and divide also waits in
// the divide state for the divider, which retires one quotient bit per cycle. A new
// item is accepted as soon as the previous one has been moved into the output
// register, even while that result still waits for m_tready; the memory needs no
// clearing after reset, since only entries below the current depth are ever read.
`include "rpn_stack_calculator_macros.svh"

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsc_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [rsc_pkg::OPCODE_W-1:0]  s_tuser,   // [2:0] opcode
    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rsc_pkg::M_TDATA_W-1:0] m_tdata    // [31:0] top_value, [36:32] depth,
                                                     // [38:37] status, [39] always 0
);
    import rsc_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] TWO        = CNT_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [WORD_W-1:0]   tos_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic [WORD_W-1:0]   val_reg;
    logic [WORD_W-1:0]   res_reg;
    status_t             status_reg;
    logic                push_reg;
    logic                pop_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                s_accept;
    logic                out_free;
    logic                commit;
    logic [CNT_W-1:0]    count_next;
    logic [WORD_W-1:0]   tos_next;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [WORD_W-1:0]   mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [WORD_W-1:0]   mem_rd_data;

    logic                div_start;
    div_status_t         div_stat;
    logic [WORD_W-1:0]   div_quotient;

    logic                over_commit;
    logic                under_commit;
    logic                div_wait;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == S_FINISH) && out_free;

    // The stack after this item: push grows it, a completed operator shrinks it
    // by one and replaces the new top with the result.
    always_comb begin
        count_next = count_reg;
        tos_next   = tos_reg;
        if (push_reg) begin
            count_next = count_reg + 1'b1;
            tos_next   = val_reg;
        end else if (pop_reg) begin
            count_next = count_reg - 1'b1;
            tos_next   = res_reg;
        end
    end

    // Only the entry below the top is ever read; writes happen on commit, so a
    // read and a write to the same entry never overlap.
    assign mem_rd_addr = ADDR_W'(count_reg - TWO);
    assign mem_wr_en   = commit && (push_reg || pop_reg);
    assign mem_wr_addr = push_reg ? ADDR_W'(count_reg) : ADDR_W'(count_reg - TWO);
    assign mem_wr_data = push_reg ? val_reg : res_reg;

    assign div_start = (state_reg == S_READ) && (op_reg == OP_DIV) && (tos_reg != '0);

    rsc_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (s_accept),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rsc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mem_rd_data),
        .divisor  (tos_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            push_reg     <= 1'b0;
            pop_reg      <= 1'b0;
        end else begin
            // A new result refills the output register in the same cycle that
            // the waiting one is taken.
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    // push_reg and pop_reg are already low here.
                    if (s_accept) begin
                        op_reg  <= s_tuser;
                        val_reg <= s_tdata;
                        case (s_tuser)
                            OP_PUSH: begin
                                state_reg <= S_FINISH;
                                if (count_reg == FULL_COUNT) begin
                                    status_reg <= ST_OVER;
                                end else begin
                                    status_reg <= ST_OK;
                                    push_reg   <= 1'b1;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (count_reg < TWO) begin
                                    status_reg <= ST_UNDER;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    status_reg <= ST_OK;
                                    pop_reg    <= 1'b1;
                                    state_reg  <= S_READ;
                                end
                            end
                            default: begin
                                // Unknown opcode: no change, status ok.
                                status_reg <= ST_OK;
                                state_reg  <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // a is the entry read from memory, b the registered top.
                    case (op_reg)
                        OP_ADD: begin
                            res_reg   <= mem_rd_data + tos_reg;
                            state_reg <= S_FINISH;
                        end
                        OP_SUB: begin
                            res_reg   <= mem_rd_data - tos_reg;
                            state_reg <= S_FINISH;
                        end
                        OP_MUL: begin
                            res_reg   <= WORD_W'(mem_rd_data * tos_reg);
                            state_reg <= S_FINISH;
                        end
                        OP_DIV: begin
                            if (tos_reg == '0) begin
                                status_reg <= ST_DIVZERO;
                                pop_reg    <= 1'b0;
                                state_reg  <= S_FINISH;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end
                        default: begin
                            pop_reg   <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        res_reg   <= div_quotient;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        count_reg    <= count_next;
                        tos_reg      <= tos_next;
                        m_tdata_reg  <= {1'b0, status_reg, DEPTH_W'(count_next),
                                         (count_next != '0) ? tos_next : '0};
                        push_reg     <= 1'b0;
                        pop_reg      <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign over_commit  = commit && (status_reg == ST_OVER);
    assign under_commit = commit && (status_reg == ST_UNDER);
    assign div_wait     = (state_reg == S_DIV);

    `RSC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "stack count beyond depth")
    `RSC_ASSERT_IMP(a_no_push_pop, 1'b1, !(push_reg && pop_reg), "push and pop both pending")
    `RSC_ASSERT_IMP(a_over_full, over_commit, count_reg == FULL_COUNT, "overflow below full")
    `RSC_ASSERT_IMP(a_under_short, under_commit, count_reg < TWO, "underflow with two entries")
    `RSC_ASSERT_IMP(a_div_idle, div_wait, div_stat.busy || div_stat.done, "divider idle")

endmodule
